// File: design/imuac_pkg.sv
package imuac_pkg;

   // Channel map and sample format.
   localparam int NUM_CHANNELS    = 10;
   localparam int CHAN_BITS       = 4;
   localparam int SAMPLE_BITS     = 16;
   localparam int TRIGGER_CHANNEL = 9;
   localparam int NUM_AXES        = 3;
   localparam int NUM_GROUPS      = 2;
   localparam int FIRST_EXTRA     = NUM_GROUPS * NUM_AXES;
   localparam int NUM_EXTRAS      = NUM_CHANNELS - FIRST_EXTRA;

   // Fixed-point formats: Q1.19 coefficients, Q16.4 biases, Q.16 results.
   localparam int FIELD_BITS = 21;
   localparam int COEF_FRAC  = 19;
   localparam int BIAS_FRAC  = 4;
   localparam int OUT_FRAC   = 16;
   localparam int OUT_BITS   = 40;
   localparam int EXTRA_BITS = 16;

   // A shifted sample plus a bias needs one bit more than the wider of the two.
   localparam int TERM_BITS = FIELD_BITS + 1;
   localparam int PROD_BITS = TERM_BITS + FIELD_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int OUT_SHIFT = COEF_FRAC + BIAS_FRAC - OUT_FRAC;

   // Stream word layouts.
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = FIRST_EXTRA * OUT_BITS + NUM_EXTRAS * EXTRA_BITS;

   // Register file and its bus.
   localparam int NUM_REGS       = 8;
   localparam int REG_BITS       = 63;
   localparam int REG_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_ADDR_BITS  = 6;
   localparam int CSR_ADDR_LSB   = 3;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_ACC_ROW_X,
      REG_ACC_ROW_Y,
      REG_ACC_ROW_Z,
      REG_GYR_ROW_X,
      REG_GYR_ROW_Y,
      REG_GYR_ROW_Z,
      REG_ACC_OFFSETS,
      REG_GYR_OFFSETS
   } reg_index_type;

   // Identity matrix and zero biases after reset.
   localparam logic [REG_BITS-1:0] ROW_X_RESET = REG_BITS'(1) << COEF_FRAC;
   localparam logic [REG_BITS-1:0] ROW_Y_RESET = ROW_X_RESET << FIELD_BITS;
   localparam logic [REG_BITS-1:0] ROW_Z_RESET = ROW_Y_RESET << FIELD_BITS;
   localparam logic [REG_BITS-1:0] REG_RESET [NUM_REGS] = '{
      ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET,
      ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET,
      '0, '0
   };

   // Saturation bounds of a result, held at the width of the sum.
   localparam logic signed [SUM_BITS-1:0] OUT_HI =
      SUM_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_BITS-1:0] OUT_LO = -OUT_HI - SUM_BITS'(1);

   // Signed coefficient or bias j of a packed register.
   function automatic logic signed [FIELD_BITS-1:0] packed_field(
      input logic [REG_BITS-1:0] word,
      input int                  j
   );
      return word[FIELD_BITS*j +: FIELD_BITS];
   endfunction

   // Raw sample moved to Q.4 with the bias added.
   function automatic logic signed [TERM_BITS-1:0] biased_term(
      input logic signed [SAMPLE_BITS-1:0] raw,
      input logic signed [FIELD_BITS-1:0]  bias
   );
      logic signed [TERM_BITS-1:0] raw_q4;
      logic signed [TERM_BITS-1:0] bias_ext;
      raw_q4   = {{(TERM_BITS - SAMPLE_BITS - BIAS_FRAC){raw[SAMPLE_BITS-1]}},
                  raw, {BIAS_FRAC{1'b0}}};
      bias_ext = {{(TERM_BITS - FIELD_BITS){bias[FIELD_BITS-1]}}, bias};
      return raw_q4 + bias_ext;
   endfunction

   // Floor to Q.16, then clamp to the signed result range.
   function automatic logic [OUT_BITS-1:0] scale_out(
      input logic signed [SUM_BITS-1:0] sum
   );
      logic signed [SUM_BITS-1:0] shifted;
      shifted = sum >>> OUT_SHIFT;
      if (shifted > OUT_HI) begin
         shifted = OUT_HI;
      end else if (shifted < OUT_LO) begin
         shifted = OUT_LO;
      end
      return shifted[OUT_BITS-1:0];
   endfunction

endpackage

// File: design/imu_affine_calibration_top.sv
// IMU affine calibration.
// The req stream carries one sensor word per transfer: a channel number and a
// raw signed sample. Channels 0-9 are written into a ten-entry raw buffer;
// channels 10-15 are dropped. A word on channel 9 also produces one frame on
// the rsp stream: calibrated acceleration and angular rate, each computed as
// C * (raw + bias) with eighteen parallel multipliers, plus the raw values of
// channels 6 to 9.
// A word is taken in every cycle while req_tready is high. After its trigger
// word, a frame passes the buffer write, the multipliers and the sums,
// rounding and clamping into the output register.
// When the receiver stalls, frames queue in the two internal stages and the
// output register; req_tready drops only once a frame waits in the first
// stage, so the buffer is never overwritten under a pending frame.
// The register port takes the matrix rows and biases at byte address 8*i and
// reads them back. Users must write it only while no frame is in flight; the
// block does not enforce it. Synchronous reset loads the identity matrix and
// zero biases, clears the raw buffer and empties the pipeline.
module imu_affine_calibration_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // [3:0] channel, [19:4] sample, [23:20] zero
   input  logic [imuac_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (40 bits each),
   // extra_six, extra_seven, extra_eight, extra_nine (16 bits each)
   output logic [imuac_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [imuac_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [imuac_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [imuac_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   logic [imuac_pkg::CHAN_BITS-1:0]   req_channel;
   logic [imuac_pkg::SAMPLE_BITS-1:0] req_sample;
   logic                              req_accept;
   logic                              req_trigger;
   logic                              csr_write;
   logic [imuac_pkg::REG_INDEX_BITS-1:0] csr_index;

   logic [imuac_pkg::REG_BITS-1:0]    cfg_ff [imuac_pkg::NUM_REGS];
   logic [imuac_pkg::SAMPLE_BITS-1:0] raw_ff [imuac_pkg::NUM_CHANNELS];

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_ready, out_ready, s2_load, out_load;

   logic signed [imuac_pkg::PROD_BITS-1:0]
      prod_ff [imuac_pkg::NUM_GROUPS][imuac_pkg::NUM_AXES][imuac_pkg::NUM_AXES];
   logic signed [imuac_pkg::PROD_BITS-1:0]
      prod_in [imuac_pkg::NUM_GROUPS][imuac_pkg::NUM_AXES][imuac_pkg::NUM_AXES];
   logic [imuac_pkg::SAMPLE_BITS-1:0] extra_ff [imuac_pkg::NUM_EXTRAS];
   logic [imuac_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Word fields and handshakes.
   assign req_channel = req_tdata[imuac_pkg::CHAN_BITS-1:0];
   assign req_sample  = req_tdata[imuac_pkg::CHAN_BITS +: imuac_pkg::SAMPLE_BITS];
   assign req_accept  = req_tvalid && req_tready;
   assign req_trigger = req_channel == imuac_pkg::CHAN_BITS'(imuac_pkg::TRIGGER_CHANNEL);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[imuac_pkg::CSR_ADDR_BITS-1:imuac_pkg::CSR_ADDR_LSB];
   assign csr_prdata = {1'b0, cfg_ff[csr_index]};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < imuac_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= imuac_pkg::REG_RESET[i];
         end
      end else if (csr_write) begin
         cfg_ff[csr_index] <= csr_pwdata[imuac_pkg::REG_BITS-1:0];
      end
   end

   // Raw buffer, written by every accepted word on a valid channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < imuac_pkg::NUM_CHANNELS; i++) begin
            raw_ff[i] <= '0;
         end
      end else if (req_accept &&
                   req_channel < imuac_pkg::CHAN_BITS'(imuac_pkg::NUM_CHANNELS)) begin
         raw_ff[req_channel] <= req_sample;
      end
   end

   // Stage handshakes: each stage moves when the one after it has room.
   always_comb begin
      out_ready    = !rsp_valid_ff || rsp_tready;
      s2_ready     = !s2_valid_ff || out_ready;
      req_tready   = !s1_valid_ff || s2_ready;
      s2_load      = s1_valid_ff && s2_ready;
      out_load     = s2_valid_ff && out_ready;
      s1_valid_in  = req_tready ? (req_accept && req_trigger) : s1_valid_ff;
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Multipliers: coefficient (r, c) times biased sample c of each group.
   always_comb begin
      for (int g = 0; g < imuac_pkg::NUM_GROUPS; g++) begin
         for (int r = 0; r < imuac_pkg::NUM_AXES; r++) begin
            for (int c = 0; c < imuac_pkg::NUM_AXES; c++) begin
               prod_in[g][r][c] =
                  imuac_pkg::packed_field(
                     cfg_ff[((g == 0) ? imuac_pkg::REG_ACC_ROW_X
                                      : imuac_pkg::REG_GYR_ROW_X) + r], c) *
                  imuac_pkg::biased_term(
                     raw_ff[g * imuac_pkg::NUM_AXES + c],
                     imuac_pkg::packed_field(
                        cfg_ff[(g == 0) ? imuac_pkg::REG_ACC_OFFSETS
                                        : imuac_pkg::REG_GYR_OFFSETS], c));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         prod_ff <= prod_in;
         for (int k = 0; k < imuac_pkg::NUM_EXTRAS; k++) begin
            extra_ff[k] <= raw_ff[imuac_pkg::FIRST_EXTRA + k];
         end
      end
   end

   // Row sums, floor to Q.16 and clamp; pack the frame.
   always_comb begin
      rsp_data_in = '0;
      for (int g = 0; g < imuac_pkg::NUM_GROUPS; g++) begin
         for (int r = 0; r < imuac_pkg::NUM_AXES; r++) begin
            rsp_data_in[imuac_pkg::OUT_BITS * (g * imuac_pkg::NUM_AXES + r)
                        +: imuac_pkg::OUT_BITS] =
               imuac_pkg::scale_out(
                  imuac_pkg::SUM_BITS'(prod_ff[g][r][0]) +
                  imuac_pkg::SUM_BITS'(prod_ff[g][r][1]) +
                  imuac_pkg::SUM_BITS'(prod_ff[g][r][2]));
         end
      end
      for (int k = 0; k < imuac_pkg::NUM_EXTRAS; k++) begin
         rsp_data_in[imuac_pkg::FIRST_EXTRA * imuac_pkg::OUT_BITS +
                     imuac_pkg::EXTRA_BITS * k +: imuac_pkg::EXTRA_BITS] = extra_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/imuac_checker.sv
module imuac_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   // [3:0] channel, [19:4] sample, [23:20] zero
   input logic [imuac_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   // six 40-bit calibrated axes, then four 16-bit raw extras
   input logic [imuac_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [imuac_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [imuac_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [imuac_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   input logic                                csr_pready
);

   logic trigger_accept;
   logic csr_write;

   assign trigger_accept = req_tvalid && req_tready &&
      (req_tdata[imuac_pkg::CHAN_BITS-1:0] ==
       imuac_pkg::CHAN_BITS'(imuac_pkg::TRIGGER_CHANNEL));
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // A stalled frame stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A frame that appears at an empty output comes from an accepted trigger word.
   a_frame_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(trigger_accept, 3))
      else $error("frame without trigger word three cycles before");

   // A written register reads back at the same address.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write |=>
         (csr_paddr[imuac_pkg::CSR_ADDR_BITS-1:imuac_pkg::CSR_ADDR_LSB] !=
          $past(csr_paddr[imuac_pkg::CSR_ADDR_BITS-1:imuac_pkg::CSR_ADDR_LSB])) ||
         (csr_prdata == {1'b0, $past(csr_pwdata[imuac_pkg::REG_BITS-1:0])}))
      else $error("register read back differs from the written word");

endmodule

bind imu_affine_calibration_top imuac_checker u_imuac_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LAST_CHANNEL = (1 << imuac_pkg::CHAN_BITS) - 1;

   // Full-scale samples of both signs.
   localparam logic [imuac_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(imuac_pkg::SAMPLE_BITS-1){1'b0}}};
   localparam logic [imuac_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(imuac_pkg::SAMPLE_BITS-1){1'b1}}};

   // One sensor word as it sits in req_tdata: channel in the low bits.
   typedef struct packed {
      logic [imuac_pkg::SAMPLE_BITS-1:0] sample;
      logic [imuac_pkg::CHAN_BITS-1:0]   channel;
   } sensor_word_type;

   // One frame as it sits in rsp_tdata: accel and rate axes low, extras high.
   typedef struct packed {
      logic [imuac_pkg::NUM_EXTRAS-1:0][imuac_pkg::EXTRA_BITS-1:0] extras;
      logic [imuac_pkg::FIRST_EXTRA-1:0][imuac_pkg::OUT_BITS-1:0]  axes;
   } imu_frame_type;

   // Ways of filling the matrix and bias registers for one phase.
   typedef enum {
      FILL_MIN,
      FILL_MAX,
      FILL_ZERO,
      FILL_RANDOM,
      FILL_NEAR_UNIT
   } reg_fill_type;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   // [3:0] channel, [19:4] sample, [23:20] zero
   logic [imuac_pkg::REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (40 bits each),
   // extra_six, extra_seven, extra_eight, extra_nine (16 bits each)
   logic [imuac_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [imuac_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [imuac_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [imuac_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                                csr_pready;

   // Our own copy of the calibration registers and of the raw buffer.
   logic [imuac_pkg::REG_BITS-1:0]    coef_regs [imuac_pkg::NUM_REGS];
   logic [imuac_pkg::SAMPLE_BITS-1:0] raw_copy  [imuac_pkg::NUM_CHANNELS];

   sensor_word_type words_to_send [$];
   imu_frame_type   frames_due    [$];

   int mismatches    = 0;
   int cycle_count   = 0;
   int src_gap       = 0;
   int snk_gap       = 0;
   int hold_left     = 0;
   int hold_requests = 0;
   int holds_started = 0;
   bit src_idling    = 1'b1;
   bit snk_idling    = 1'b1;

   string axis_names  [imuac_pkg::FIRST_EXTRA] = '{"accel_x", "accel_y", "accel_z",
                                                   "rate_x", "rate_y", "rate_z"};
   string extra_names [imuac_pkg::NUM_EXTRAS]  = '{"extra_six", "extra_seven",
                                                   "extra_eight", "extra_nine"};

   imu_affine_calibration_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Prints one line per mismatch and counts them all.
   task automatic report_mismatch(input string msg);
      $display("%0t ERROR %s", $time, msg);
      mismatches++;
   endtask

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Sample values lean toward the extremes of the signed range.
   function automatic logic [imuac_pkg::SAMPLE_BITS-1:0] random_sample();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)  return SAMPLE_MIN;
      if (roll < 16) return SAMPLE_MAX;
      if (roll < 20) return '0;
      if (roll < 24) return '1;
      return imuac_pkg::SAMPLE_BITS'($urandom);
   endfunction

   function automatic void queue_word(input int channel,
                                      input logic [imuac_pkg::SAMPLE_BITS-1:0] sample);
      sensor_word_type w;
      w.channel = imuac_pkg::CHAN_BITS'(channel);
      w.sample  = sample;
      words_to_send.push_back(w);
   endfunction

   // One calibrated axis: row times (raw in Q.4 plus bias), floored to Q.16
   // and clamped to the signed output range.
   function automatic logic [imuac_pkg::OUT_BITS-1:0] calibrated_axis(
      input logic [imuac_pkg::REG_BITS-1:0] row,
      input logic [imuac_pkg::REG_BITS-1:0] offsets,
      input int                             base
   );
      logic signed [imuac_pkg::FIELD_BITS-1:0]  coef_bits;
      logic signed [imuac_pkg::FIELD_BITS-1:0]  bias_bits;
      logic signed [imuac_pkg::SAMPLE_BITS-1:0] raw_bits;
      longint                                   total;
      longint                                   hi_bound;
      total    = 0;
      hi_bound = (longint'(1) <<< (imuac_pkg::OUT_BITS - 1)) - 1;
      for (int j = 0; j < imuac_pkg::NUM_AXES; j++) begin
         coef_bits = row[imuac_pkg::FIELD_BITS*j +: imuac_pkg::FIELD_BITS];
         bias_bits = offsets[imuac_pkg::FIELD_BITS*j +: imuac_pkg::FIELD_BITS];
         raw_bits  = raw_copy[base + j];
         total += longint'(coef_bits) *
                  (longint'(raw_bits) * (longint'(1) << imuac_pkg::BIAS_FRAC) +
                   longint'(bias_bits));
      end
      total = total >>> (imuac_pkg::COEF_FRAC + imuac_pkg::BIAS_FRAC - imuac_pkg::OUT_FRAC);
      if (total > hi_bound) begin
         total = hi_bound;
      end else if (total < -hi_bound - 1) begin
         total = -hi_bound - 1;
      end
      return total[imuac_pkg::OUT_BITS-1:0];
   endfunction

   // Applies one accepted word to the raw buffer copy; a trigger word
   // also queues the frame it must produce.
   task automatic absorb_word(input sensor_word_type w);
      imu_frame_type frame;
      if (w.channel >= imuac_pkg::NUM_CHANNELS) return;
      raw_copy[w.channel] = w.sample;
      if (w.channel != imuac_pkg::TRIGGER_CHANNEL) return;
      for (int r = 0; r < imuac_pkg::NUM_AXES; r++) begin
         frame.axes[r] =
            calibrated_axis(coef_regs[imuac_pkg::REG_ACC_ROW_X + r],
                            coef_regs[imuac_pkg::REG_ACC_OFFSETS], 0);
         frame.axes[imuac_pkg::NUM_AXES + r] =
            calibrated_axis(coef_regs[imuac_pkg::REG_GYR_ROW_X + r],
                            coef_regs[imuac_pkg::REG_GYR_OFFSETS], imuac_pkg::NUM_AXES);
      end
      for (int e = 0; e < imuac_pkg::NUM_EXTRAS; e++) begin
         frame.extras[e] = raw_copy[imuac_pkg::FIRST_EXTRA + e];
      end
      frames_due.push_back(frame);
   endtask

   // Compares one received frame with the oldest one still due.
   task automatic check_frame(input imu_frame_type got);
      imu_frame_type want;
      if (frames_due.size() == 0) begin
         report_mismatch("frame received while none was due");
         return;
      end
      want = frames_due.pop_front();
      for (int a = 0; a < imuac_pkg::FIRST_EXTRA; a++) begin
         if (got.axes[a] !== want.axes[a]) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", axis_names[a],
                                      $signed(got.axes[a]), $signed(want.axes[a])));
         end
      end
      for (int e = 0; e < imuac_pkg::NUM_EXTRAS; e++) begin
         if (got.extras[e] !== want.extras[e]) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", extra_names[e],
                                      $signed(got.extras[e]), $signed(want.extras[e])));
         end
      end
   endtask

   // Sender: presents queued words with random gaps and predicts each
   // word at the edge where it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_word(sensor_word_type'(
               req_tdata[imuac_pkg::CHAN_BITS+imuac_pkg::SAMPLE_BITS-1:0]));
         end
         if (!req_tvalid || req_tready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_tvalid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
               req_tdata  <= imuac_pkg::REQ_DATA_BITS'(words_to_send.pop_front());
               req_tvalid <= 1'b1;
               src_gap = src_idling ? idle_length() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks frames, stalls at random, and on request holds off
   // for a long stretch so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_frame(imu_frame_type'(rsp_tdata));
         end
         if (hold_requests != holds_started) begin
            holds_started = hold_requests;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (snk_gap > 0) begin
            snk_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            snk_gap = snk_idling ? idle_length() : 0;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // One register transfer with a setup and an access phase. A read is
   // checked against our copy of the register.
   task automatic csr_access(
      input bit                             is_write,
      input imuac_pkg::reg_index_type       idx,
      input logic [imuac_pkg::REG_BITS-1:0] value
   );
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= imuac_pkg::CSR_ADDR_BITS'(idx) << imuac_pkg::CSR_ADDR_LSB;
      csr_pwdata  <= is_write ? imuac_pkg::CSR_DATA_BITS'(value) : '0;
      @(posedge clock);
      csr_penable <= 1'b1;
      // The access ends at the first edge that finds pready high.
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      if (!is_write && csr_prdata[imuac_pkg::REG_BITS-1:0] !== coef_regs[idx]) begin
         report_mismatch($sformatf("%s reads %h, expected %h", idx.name(),
                                   csr_prdata[imuac_pkg::REG_BITS-1:0], coef_regs[idx]));
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (is_write) coef_regs[idx] = value;
   endtask

   function automatic logic [imuac_pkg::REG_BITS-1:0] register_value(
      input reg_fill_type fill,
      input int           idx
   );
      logic [imuac_pkg::FIELD_BITS-1:0] field;
      logic [imuac_pkg::REG_BITS-1:0]   packed_word;
      packed_word = '0;
      for (int j = 0; j < imuac_pkg::NUM_AXES; j++) begin
         case (fill)
            FILL_MIN:    field = {1'b1, {(imuac_pkg::FIELD_BITS-1){1'b0}}};
            FILL_MAX:    field = {1'b0, {(imuac_pkg::FIELD_BITS-1){1'b1}}};
            FILL_ZERO:   field = '0;
            FILL_RANDOM: field = imuac_pkg::FIELD_BITS'($urandom);
            default: begin
               // A plausible calibration: near-unit diagonal, small cross
               // terms and small biases.
               if (idx < imuac_pkg::REG_ACC_OFFSETS && j == idx % imuac_pkg::NUM_AXES) begin
                  field = imuac_pkg::FIELD_BITS'((1 << imuac_pkg::COEF_FRAC) +
                                                 int'($urandom_range(0, 16383)) - 8192);
               end else begin
                  field = imuac_pkg::FIELD_BITS'(int'($urandom_range(0, 8191)) - 4096);
               end
            end
         endcase
         packed_word[imuac_pkg::FIELD_BITS*j +: imuac_pkg::FIELD_BITS] = field;
      end
      return packed_word;
   endfunction

   // Writes every register and reads each one back.
   task automatic program_registers(input reg_fill_type fill);
      for (int i = 0; i < imuac_pkg::NUM_REGS; i++) begin
         csr_access(1'b1, imuac_pkg::reg_index_type'(i), register_value(fill, i));
         csr_access(1'b0, imuac_pkg::reg_index_type'(i), '0);
      end
   endtask

   // Waits until every word is taken and every frame has come back, then
   // gives the pipeline time to finish words that make no frame.
   task automatic wait_until_drained();
      @(negedge clock);
      while (words_to_send.size() != 0 || req_tvalid || frames_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Full-scale samples on every calibrated channel, both signs.
   task automatic queue_extremes();
      for (int ch = 0; ch < imuac_pkg::FIRST_EXTRA; ch++) queue_word(ch, SAMPLE_MIN);
      queue_word(imuac_pkg::TRIGGER_CHANNEL, SAMPLE_MIN);
      for (int ch = 0; ch < imuac_pkg::FIRST_EXTRA; ch++) queue_word(ch, SAMPLE_MAX);
      queue_word(imuac_pkg::TRIGGER_CHANNEL, SAMPLE_MAX);
   endtask

   // Mostly runs of channel words closed by a trigger, plus some words on
   // unused channels and some runs that never reach a trigger.
   task automatic queue_random_traffic(input int target, input int max_lead);
      int sent;
      int lead;
      int roll;
      sent = 0;
      while (sent < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            queue_word($urandom_range(imuac_pkg::NUM_CHANNELS, LAST_CHANNEL), random_sample());
            sent += 1;
         end else if (roll < 15) begin
            lead = $urandom_range(1, 4);
            repeat (lead) begin
               queue_word($urandom_range(0, imuac_pkg::TRIGGER_CHANNEL - 1), random_sample());
            end
            sent += lead;
         end else begin
            lead = $urandom_range(0, max_lead);
            repeat (lead) begin
               queue_word($urandom_range(0, imuac_pkg::TRIGGER_CHANNEL - 1), random_sample());
            end
            queue_word(imuac_pkg::TRIGGER_CHANNEL, random_sample());
            sent += lead + 1;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < imuac_pkg::NUM_REGS; i++) coef_regs[i] = imuac_pkg::REG_RESET[i];
      for (int ch = 0; ch < imuac_pkg::NUM_CHANNELS; ch++) raw_copy[ch] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset values must read back as the identity and zero biases.
      for (int i = 0; i < imuac_pkg::NUM_REGS; i++) begin
         csr_access(1'b0, imuac_pkg::reg_index_type'(i), '0);
      end

      // A trigger on the freshly cleared buffer.
      queue_word(imuac_pkg::TRIGGER_CHANNEL, 16'h1234);
      // Channels 0 to 8 at the negative extreme, then a trigger at the positive one.
      for (int ch = 0; ch < imuac_pkg::TRIGGER_CHANNEL; ch++) queue_word(ch, SAMPLE_MIN);
      queue_word(imuac_pkg::TRIGGER_CHANNEL, SAMPLE_MAX);
      // Positive extremes, then words on unused channels that must change
      // nothing before the next trigger.
      for (int ch = 0; ch < imuac_pkg::FIRST_EXTRA; ch++) queue_word(ch, SAMPLE_MAX);
      for (int ch = imuac_pkg::NUM_CHANNELS; ch <= LAST_CHANNEL; ch++) begin
         queue_word(ch, imuac_pkg::SAMPLE_BITS'($urandom));
      end
      queue_word(imuac_pkg::TRIGGER_CHANNEL, SAMPLE_MIN);
      wait_until_drained();

      queue_random_traffic(150, 9);
      wait_until_drained();

      // Extreme coefficients and biases.
      program_registers(FILL_MIN);
      queue_extremes();
      queue_random_traffic(100, 9);
      wait_until_drained();

      program_registers(FILL_MAX);
      queue_extremes();
      queue_random_traffic(100, 9);
      wait_until_drained();

      program_registers(FILL_ZERO);
      queue_random_traffic(40, 9);
      wait_until_drained();

      // The receiver holds off for a long stretch while the sender keeps
      // offering dense frames, so the block has to stall its input.
      program_registers(FILL_NEAR_UNIT);
      src_idling = 1'b0;
      snk_idling = 1'b0;
      hold_requests <= hold_requests + 1;
      queue_random_traffic(150, 2);
      wait_until_drained();

      // Further settings; one phase runs with no idling on either side.
      for (int k = 0; k < 4; k++) begin
         program_registers(k % 2 == 0 ? FILL_RANDOM : FILL_NEAR_UNIT);
         src_idling = (k != 2);
         snk_idling = (k != 2);
         queue_extremes();
         queue_random_traffic(120, 9);
         wait_until_drained();
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
